// File: hdl/ps2_mouse_device_assert.svh
// Assertion macros for the PS/2 mouse device
`ifndef PS2_MOUSE_DEVICE_ASSERT_SVH
`define PS2_MOUSE_DEVICE_ASSERT_SVH
// implication checked on every clock, disabled in reset
`define PS2M_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define PS2M_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// File: hdl/ps2m_pkg.sv
// Package for the PS/2 mouse device: codes, constants and sequencer states
package ps2m_pkg;
	localparam int QUEUE_DEPTH_DEF = 256;
	localparam logic [2:0] KIND_HOST = 3'd0;
	localparam logic [2:0] KIND_MOVE = 3'd1;
	localparam logic [2:0] KIND_BTN  = 3'd2;
	localparam logic [2:0] KIND_TICK = 3'd3;
	localparam logic [2:0] KIND_TAKE = 3'd4;
	localparam logic [7:0] BYTE_ACK    = 8'hFA;
	localparam logic [7:0] BYTE_BAT    = 8'hAA;
	localparam logic [7:0] BYTE_RESEND = 8'hFE;
	localparam logic [7:0] CMD_RESET   = 8'hFF;
	localparam logic [7:0] CMD_RESEND  = 8'hFE;
	localparam logic [7:0] CMD_DEFAULT = 8'hF6;
	localparam logic [7:0] CMD_DISABLE = 8'hF5;
	localparam logic [7:0] CMD_ENABLE  = 8'hF4;
	localparam logic [7:0] CMD_RATE    = 8'hF3;
	localparam logic [7:0] CMD_ID      = 8'hF2;
	localparam logic [7:0] CMD_REMOTE  = 8'hF0;
	localparam logic [7:0] CMD_WRAP    = 8'hEE;
	localparam logic [7:0] CMD_NOWRAP  = 8'hEC;
	localparam logic [7:0] CMD_READ    = 8'hEB;
	localparam logic [7:0] CMD_STREAM  = 8'hEA;
	localparam logic [7:0] CMD_STATUS  = 8'hE9;
	localparam logic [7:0] CMD_SCALE2  = 8'hE7;
	localparam logic [7:0] CMD_SCALE1  = 8'hE6;
	localparam logic [7:0] CMD_RES     = 8'hE8;
	localparam logic [7:0] RATE_DEF    = 8'd100;
	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
	localparam int DIV_BITS = 30;
	typedef enum logic [2:0] {
		ST_IDLE, ST_EMIT, ST_DIV, ST_ADD, ST_DONE
	} state_t;
endpackage

// File: hdl/ps2_mouse_device.sv
// PS/2 mouse device: command handling, motion tracking, packet timing, reply queue
// Usage:
// Input channel (in_valid/in_stall) carries one item: kind selects a host byte,
// a pointer move, a button change, a time tick or a take of one queued byte.
// Output channel (out_valid_h/out_stall) returns exactly one result per item:
// out_byte, out_valid and bytes_pending.
// An item that queues nothing passes through the EMIT state before its
// result is offered; each queued byte is written in its own EMIT step, and a
// packet takes one more step to latch its bytes. A tick that sends a packet
// also runs a 30-step restoring divider for the sample period plus one add step.
// One item is handled at a time; in_stall is high from acceptance until the
// result has been taken, so no new item is accepted before the last is through.
// The reply queue is a memory written one byte per cycle, read with a registered
// port; bytes that do not fit are dropped.
// Reset (arst_n low) restores all mode, rate and motion state to power-on values
// and empties the queue; no clearing pass is needed.
// When out_stall is high the result holds and no new item is accepted.
module ps2_mouse_device #(
	parameter int QUEUE_DEPTH = ps2m_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  host_byte,
	input  logic [15:0] pointer_x,
	input  logic [15:0] pointer_y,
	input  logic [1:0]  button_index,
	input  logic        button_down,
	input  logic [63:0] now_ns,
	output logic        out_valid_h,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        bytes_pending
);
	import ps2m_pkg::*;
	localparam int AW = $clog2(QUEUE_DEPTH);
	typedef logic [AW-1:0] qptr_t;

	state_t state_q, state_d;
	logic [7:0] mem [QUEUE_DEPTH];
	qptr_t head_q, tail_q;
	logic rep_q, remote_q, wrap_q, scale_q, motion_q, seen_q;
	logic [7:0] rate_q, pend_q, last_q;
	logic [1:0] res_q;
	logic [2:0] btn_q, rbtn_q;
	logic signed [23:0] dx_q, dy_q;
	logic [15:0] hx_q, hy_q;
	logic [63:0] npt_q, now_q;
	logic [7:0] eb_q [4];
	logic [2:0] ecnt_q, eidx_q;
	logic pkt_q, div_q;
	logic [29:0] quo_q;
	logic [29:0] rem_q;
	logic [4:0] dcnt_q;
	logic [7:0] ob_q;
	logic ov_q, rvalid_q;
	logic accept;

	function automatic qptr_t qnext(input qptr_t p);
		return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
	endfunction

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid_h = (state_q == ST_DONE);
	assign bytes_pending = (head_q != tail_q);

	// packet build from current accumulators
	logic signed [23:0] cx, cy;
	logic [7:0] pst;
	always_comb begin
		pst = {5'b00001, btn_q};
		cx = dx_q;
		cy = dy_q;
		if (dx_q > 24'sd255) begin
			cx = 24'sd255; pst[6] = 1'b1;
		end else if (dx_q < -24'sd256) begin
			cx = -24'sd256; pst[6] = 1'b1;
		end
		if (dy_q > 24'sd255) begin
			cy = 24'sd255; pst[7] = 1'b1;
		end else if (dy_q < -24'sd256) begin
			cy = -24'sd256; pst[7] = 1'b1;
		end
		pst[4] = cx[23];
		pst[5] = cy[23];
	end

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607) return 24'sh7FFFFF;
		if (v < -26'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_EMIT;
			ST_EMIT: if (eidx_q >= ecnt_q) state_d = div_q ? ST_DIV : ST_DONE;
			ST_DIV:  if (dcnt_q == 5'd0) state_d = ST_ADD;
			ST_ADD:  state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic [30:0] trial;
	assign trial = {rem_q, quo_q[29]} - {23'd0, rate_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && !pkt_q && eidx_q < ecnt_q && qnext(tail_q) != head_q)
			mem[tail_q] <= eb_q[eidx_q[1:0]];
		if (accept) ob_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0; tail_q <= '0;
			rep_q <= 1'b0; remote_q <= 1'b0; wrap_q <= 1'b0; scale_q <= 1'b0;
			motion_q <= 1'b0; seen_q <= 1'b0;
			rate_q <= RATE_DEF; pend_q <= 8'd0; last_q <= 8'd0; res_q <= 2'd2;
			btn_q <= 3'd0; rbtn_q <= 3'd0; dx_q <= '0; dy_q <= '0;
			hx_q <= '0; hy_q <= '0; npt_q <= '0; now_q <= '0;
			ecnt_q <= '0; eidx_q <= '0; pkt_q <= 1'b0; div_q <= 1'b0;
			quo_q <= '0; rem_q <= '0; dcnt_q <= '0;
			ov_q <= 1'b0; rvalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) eb_q[i] <= 8'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (accept) begin
					ecnt_q <= '0; eidx_q <= '0; pkt_q <= 1'b0; div_q <= 1'b0;
					ov_q <= 1'b0; rvalid_q <= 1'b0; now_q <= now_ns;
					case (kind)
						KIND_HOST: begin
							if (pend_q != 8'd0) begin
								if (pend_q == CMD_RATE)
									rate_q <= (host_byte == 8'd0) ? RATE_DEF : host_byte;
								else if (pend_q == CMD_RES) res_q <= host_byte[1:0];
								pend_q <= 8'd0;
								eb_q[0] <= BYTE_ACK; ecnt_q <= 3'd1;
							end else if (wrap_q && host_byte != CMD_NOWRAP &&
									host_byte != CMD_RESET) begin
								eb_q[0] <= host_byte; ecnt_q <= 3'd1;
							end else begin
								eb_q[0] <= BYTE_ACK; ecnt_q <= 3'd1;
								case (host_byte)
									CMD_RESET, CMD_DEFAULT: begin
										rep_q <= 1'b0; remote_q <= 1'b0; wrap_q <= 1'b0;
										scale_q <= 1'b0; rate_q <= RATE_DEF; res_q <= 2'd2;
										dx_q <= '0; dy_q <= '0; motion_q <= 1'b0;
										if (host_byte == CMD_RESET) begin
											eb_q[1] <= BYTE_BAT; eb_q[2] <= 8'h00;
											ecnt_q <= 3'd3;
										end
									end
									CMD_RESEND: eb_q[0] <= last_q;
									CMD_DISABLE: rep_q <= 1'b0;
									CMD_ENABLE: begin
										rep_q <= 1'b1; dx_q <= '0; dy_q <= '0;
										motion_q <= 1'b0;
									end
									CMD_RATE, CMD_RES: pend_q <= host_byte;
									CMD_ID: begin
										eb_q[1] <= 8'h00; ecnt_q <= 3'd2;
									end
									CMD_REMOTE: remote_q <= 1'b1;
									CMD_WRAP: wrap_q <= 1'b1;
									CMD_NOWRAP: wrap_q <= 1'b0;
									CMD_READ: begin
										pkt_q <= 1'b1; ecnt_q <= 3'd4;
									end
									CMD_STREAM: remote_q <= 1'b0;
									CMD_STATUS: begin
										eb_q[1] <= {1'b0, remote_q, rep_q, scale_q, 1'b0,
											btn_q[0], btn_q[2], btn_q[1]};
										eb_q[2] <= {6'd0, res_q};
										eb_q[3] <= rate_q;
										ecnt_q <= 3'd4;
									end
									CMD_SCALE2: scale_q <= 1'b1;
									CMD_SCALE1: scale_q <= 1'b0;
									default: eb_q[0] <= BYTE_RESEND;
								endcase
							end
						end
						KIND_MOVE: begin
							if (seen_q && rep_q) begin
								dx_q <= sat24(26'(dx_q) + 26'($signed({1'b0, pointer_x}))
									- 26'($signed({1'b0, hx_q})));
								dy_q <= sat24(26'(dy_q) - 26'($signed({1'b0, pointer_y}))
									+ 26'($signed({1'b0, hy_q})));
								if (pointer_x != hx_q || pointer_y != hy_q) motion_q <= 1'b1;
							end
							hx_q <= pointer_x; hy_q <= pointer_y; seen_q <= 1'b1;
						end
						KIND_BTN: if (button_index != 2'd3)
							btn_q[button_index] <= button_down;
						KIND_TICK: begin
							if (rep_q && !remote_q && !wrap_q &&
									(motion_q || btn_q != rbtn_q) &&
									head_q == tail_q && now_ns >= npt_q) begin
								pkt_q <= 1'b1; div_q <= 1'b1; ecnt_q <= 3'd3;
							end
						end
						KIND_TAKE: if (head_q != tail_q) begin
							ov_q <= 1'b1; head_q <= qnext(head_q);
						end
						default: ;
					endcase
				end
				ST_EMIT: begin
					if (pkt_q) begin
						// latch packet bytes, positioned after the ACK if read-data
						pkt_q <= 1'b0;
						if (ecnt_q == 3'd4) begin
							eb_q[1] <= pst; eb_q[2] <= cx[7:0]; eb_q[3] <= cy[7:0];
						end else begin
							eb_q[0] <= pst; eb_q[1] <= cx[7:0]; eb_q[2] <= cy[7:0];
						end
						dx_q <= dx_q - cx; dy_q <= dy_q - cy;
						if (dx_q == cx && dy_q == cy) motion_q <= 1'b0;
						rbtn_q <= btn_q;
						quo_q <= NS_PER_SEC[29:0]; rem_q <= '0;
						dcnt_q <= 5'(DIV_BITS - 1);
					end else if (eidx_q < ecnt_q) begin
						if (qnext(tail_q) != head_q) begin
							tail_q <= qnext(tail_q);
							last_q <= eb_q[eidx_q[1:0]];
						end
						eidx_q <= eidx_q + 3'd1;
					end
					rvalid_q <= ov_q;
				end
				ST_DIV: begin
					if (!trial[30]) rem_q <= trial[29:0];
					else rem_q <= {rem_q[28:0], quo_q[29]};
					quo_q <= {quo_q[28:0], ~trial[30]};
					dcnt_q <= dcnt_q - 5'd1;
				end
				ST_ADD: npt_q <= now_q + {34'd0, quo_q};
				default: ;
			endcase
		end
	end

	assign out_valid = rvalid_q;
	assign out_byte = rvalid_q ? ob_q : 8'd0;

	`include "ps2_mouse_device_assert.svh"
	`PS2M_ASSERT_IMP(a_stall_busy, state_q != ST_IDLE, in_stall)
	`PS2M_ASSERT_NXT(a_done_hold, out_valid_h && out_stall, out_valid_h)
	`PS2M_ASSERT_IMP(a_ob_zero, !out_valid, out_byte == 8'd0)
	`PS2M_ASSERT_NXT(a_tail_step, state_q == ST_IDLE, $stable(tail_q))
endmodule

// File: test/tb_ps2_mouse_device.sv
// Self-checking testbench for the PS/2 mouse device: directed and random transactions
`timescale 1ns / 100ps

module tb_ps2_mouse_device;
	import ps2m_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  hb;
		logic [15:0] px;
		logic [15:0] py;
		logic [1:0]  bi;
		logic        bd;
		logic [63:0] now;
	} mouse_txn_t;

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       pend;
	} reply_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int QUEUE_CAP = QUEUE_DEPTH_DEF - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic [7:0] host_byte = '0;
	logic [15:0] pointer_x = '0;
	logic [15:0] pointer_y = '0;
	logic [1:0] button_index = '0;
	logic button_down = 1'b0;
	logic [63:0] now_ns = '0;
	logic out_valid_h;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic out_valid;
	logic bytes_pending;

	ps2_mouse_device uut (.*);

	initial forever #1 clk = ~clk;

	// mirror of the device state
	bit m_report, m_remote, m_wrap, m_scale2;
	logic [7:0] m_rate = RATE_DEF;
	logic [1:0] m_res = 2'd2;
	logic [7:0] m_pend_cmd = 8'h00;
	logic [7:0] m_last = 8'h00;
	logic [2:0] m_btn = 3'd0;
	logic [2:0] m_rep_btn = 3'd0;
	int m_dx, m_dy;
	bit m_motion, m_seen;
	logic [15:0] m_hx = 16'd0;
	logic [15:0] m_hy = 16'd0;
	logic [63:0] m_next_time = 64'd0;
	logic [7:0] reply_fifo[$];

	mouse_txn_t stim_q[$];
	reply_t expected_q[$];
	int mismatches, checked, accepted, packets, drops, idle_cycles;
	bit timed_out;

	task automatic queue_byte(input logic [7:0] b);
		if (reply_fifo.size() < QUEUE_CAP) begin
			reply_fifo.push_back(b);
			m_last = b;
		end else
			drops++;
	endtask

	task automatic load_defaults();
		m_report = 0; m_remote = 0; m_wrap = 0; m_scale2 = 0;
		m_rate = RATE_DEF; m_res = 2'd2; m_pend_cmd = 8'h00;
		m_dx = 0; m_dy = 0; m_motion = 0;
	endtask

	task automatic emit_packet();
		int cx, cy;
		logic [7:0] st;
		cx = m_dx; cy = m_dy;
		st = 8'h08 | {5'b0, m_btn};
		if (cx > 255) begin cx = 255; st |= 8'h40; end
		else if (cx < -256) begin cx = -256; st |= 8'h40; end
		if (cy > 255) begin cy = 255; st |= 8'h80; end
		else if (cy < -256) begin cy = -256; st |= 8'h80; end
		if (cx < 0) st |= 8'h10;
		if (cy < 0) st |= 8'h20;
		queue_byte(st);
		queue_byte(cx[7:0]);
		queue_byte(cy[7:0]);
		m_dx -= cx; m_dy -= cy;
		if (m_dx == 0 && m_dy == 0) m_motion = 0;
		m_rep_btn = m_btn;
		packets++;
	endtask

	function automatic int sat24(longint v);
		if (v > 64'sd8388607) return 8388607;
		if (v < -64'sd8388608) return -8388608;
		return int'(v);
	endfunction

	task automatic host_command(input logic [7:0] v);
		if (m_pend_cmd != 8'h00) begin
			if (m_pend_cmd == CMD_RATE) m_rate = (v != 0) ? v : RATE_DEF;
			else if (m_pend_cmd == CMD_RES) m_res = v[1:0];
			m_pend_cmd = 8'h00;
			queue_byte(BYTE_ACK);
			return;
		end
		if (m_wrap && v != CMD_NOWRAP && v != CMD_RESET) begin
			queue_byte(v);
			return;
		end
		case (v)
			CMD_RESET: begin
				load_defaults();
				queue_byte(BYTE_ACK); queue_byte(BYTE_BAT); queue_byte(8'h00);
			end
			CMD_RESEND: queue_byte(m_last);
			CMD_DEFAULT: begin load_defaults(); queue_byte(BYTE_ACK); end
			CMD_DISABLE: begin m_report = 0; queue_byte(BYTE_ACK); end
			CMD_ENABLE: begin
				m_report = 1; m_dx = 0; m_dy = 0; m_motion = 0;
				queue_byte(BYTE_ACK);
			end
			CMD_RATE, CMD_RES: begin m_pend_cmd = v; queue_byte(BYTE_ACK); end
			CMD_ID: begin queue_byte(BYTE_ACK); queue_byte(8'h00); end
			CMD_REMOTE: begin m_remote = 1; queue_byte(BYTE_ACK); end
			CMD_WRAP: begin m_wrap = 1; queue_byte(BYTE_ACK); end
			CMD_NOWRAP: begin m_wrap = 0; queue_byte(BYTE_ACK); end
			CMD_READ: begin queue_byte(BYTE_ACK); emit_packet(); end
			CMD_STREAM: begin m_remote = 0; queue_byte(BYTE_ACK); end
			CMD_STATUS: begin
				queue_byte(BYTE_ACK);
				queue_byte({1'b0, m_remote, m_report, m_scale2, 1'b0,
					m_btn[0], m_btn[2], m_btn[1]});
				queue_byte({6'b0, m_res});
				queue_byte(m_rate);
			end
			CMD_SCALE2: begin m_scale2 = 1; queue_byte(BYTE_ACK); end
			CMD_SCALE1: begin m_scale2 = 0; queue_byte(BYTE_ACK); end
			default: queue_byte(BYTE_RESEND);
		endcase
	endtask

	task automatic predict_reply(input mouse_txn_t t, output reply_t r);
		r = '0;
		case (t.kind)
			KIND_HOST: host_command(t.hb);
			KIND_MOVE: begin
				if (m_seen && m_report) begin
					m_dx = sat24(longint'(m_dx) + (longint'(t.px) - longint'(m_hx)));
					m_dy = sat24(longint'(m_dy) - (longint'(t.py) - longint'(m_hy)));
					if (t.px != m_hx || t.py != m_hy) m_motion = 1;
				end
				m_hx = t.px; m_hy = t.py; m_seen = 1;
			end
			KIND_BTN: if (t.bi != 2'd3) m_btn[t.bi] = t.bd;
			KIND_TICK: begin
				if (m_report && !m_remote && !m_wrap
					&& (m_motion || m_btn != m_rep_btn)
					&& reply_fifo.size() == 0 && t.now >= m_next_time) begin
					emit_packet();
					m_next_time = t.now + NS_PER_SEC / 64'(m_rate);
				end
			end
			KIND_TAKE: if (reply_fifo.size() != 0) begin
				r.data = reply_fifo.pop_front();
				r.vld = 1'b1;
			end
			default: ;
		endcase
		r.pend = (reply_fifo.size() != 0);
	endtask

	// driver
	int in_gap = 0;
	bit no_idle;
	always @(posedge clk) begin
		mouse_txn_t t;
		reply_t p;
		bit load;
		if (arst_n) begin
			load = !in_valid;
			if (in_valid && !in_stall) begin
				t = {kind, host_byte, pointer_x, pointer_y, button_index, button_down, now_ns};
				predict_reply(t, p);
				expected_q.push_back(p);
				accepted++;
				in_gap = no_idle ? 0 : int'($urandom_range(0, 4));
				load = 1;
			end
			if (load) begin
				if (in_gap > 0 || stim_q.size() == 0) begin
					if (in_gap > 0) in_gap--;
					in_valid <= 1'b0;
				end else begin
					t = stim_q.pop_front();
					in_valid <= 1'b1;
					{kind, host_byte, pointer_x, pointer_y, button_index, button_down,
						now_ns} <= t;
				end
			end
		end
	end

	// long receiver hold-off
	int hold_off = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off > 0)
				hold_off <= hold_off - 1;
			else if (!hold_done && checked >= 500) begin
				hold_off <= 400;
				hold_done <= 1'b1;
			end
		end
	end

	// monitor
	int out_wait = 0;
	always @(posedge clk) begin
		reply_t e;
		if (arst_n) begin
			if (out_valid_h && !out_stall) begin
				checked++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transaction: %h %b %b",
						out_byte, out_valid, bytes_pending);
				end else begin
					e = expected_q.pop_front();
					if (e.data !== out_byte || e.vld !== out_valid
						|| e.pend !== bytes_pending) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: exp byte %h valid %b pending %b, got %h %b %b",
								checked, e.data, e.vld, e.pend, out_byte, out_valid,
								bytes_pending);
					end
				end
				out_wait = no_idle ? 0 : int'($urandom_range(0, 4));
			end else if (out_wait > 0)
				out_wait--;
			out_stall <= (out_wait > 0) || (hold_off > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid_h && !out_stall))
				idle_cycles = 0;
			else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					timed_out = 1'b1;
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	logic [63:0] clock_ns;

	task automatic add(input logic [2:0] k, input logic [7:0] hb,
		input logic [15:0] px = 16'($urandom), input logic [15:0] py = 16'($urandom));
		mouse_txn_t t;
		t.kind = k; t.hb = hb; t.px = px; t.py = py;
		t.bi = 2'($urandom); t.bd = 1'($urandom); t.now = {$urandom, $urandom};
		stim_q.push_back(t);
	endtask

	task automatic add_btn(input logic [1:0] idx, input logic down);
		add(KIND_BTN, 8'($urandom));
		stim_q[$].bi = idx; stim_q[$].bd = down;
	endtask

	task automatic add_tick(input logic [63:0] at);
		add(KIND_TICK, 8'($urandom));
		stim_q[$].now = at;
	endtask

	task automatic add_takes(input int n);
		repeat (n) add(KIND_TAKE, 8'($urandom));
	endtask

	initial begin
		logic [7:0] cmds[16];
		logic [7:0] c;
		int r;
		cmds = '{CMD_RESET, CMD_RESEND, CMD_DEFAULT, CMD_DISABLE, CMD_ENABLE, CMD_RATE,
			CMD_ID, CMD_REMOTE, CMD_WRAP, CMD_NOWRAP, CMD_READ, CMD_STREAM, CMD_STATUS,
			CMD_SCALE2, CMD_SCALE1, CMD_RES};
		clock_ns = 0;
		// directed
		add_takes(1);
		add(3'd5, 8'hFF); add(3'd7, 8'h00);
		add(KIND_HOST, 8'h00);
		add(KIND_HOST, CMD_RATE); add(KIND_HOST, 8'h00);
		add(KIND_HOST, CMD_RES); add(KIND_HOST, 8'hFF);
		add(KIND_HOST, CMD_STATUS);
		add(KIND_HOST, CMD_WRAP); add(KIND_HOST, 8'h55); add(KIND_HOST, CMD_NOWRAP);
		add_btn(2'd3, 1'b1);
		add(KIND_HOST, CMD_ENABLE);
		add(KIND_MOVE, 8'($urandom), 16'h0000, 16'hFFFF);
		add(KIND_MOVE, 8'($urandom), 16'hFFFF, 16'h0000);
		add_btn(2'd2, 1'b1);
		add_takes(22);
		add_tick(64'hFFFF_FFFF_FFFF_FFF0);
		add(KIND_HOST, CMD_READ);
		add_takes(8);
		add(KIND_HOST, CMD_RESET);
		add(KIND_HOST, CMD_ENABLE);
		// random
		while (stim_q.size() < 950) begin
			if (stim_q.size() > 600 && stim_q.size() < 610) begin
				repeat (70) add(KIND_HOST, CMD_STATUS);
				add(KIND_HOST, CMD_RESEND);
				add_takes(260);
			end
			r = $urandom_range(0, 99);
			if (r < 25) add_takes(int'($urandom_range(1, 4)));
			else if (r < 42) begin
				clock_ns += 64'($urandom_range(0, 15_000_000));
				add_tick(clock_ns);
			end else if (r < 58) add(KIND_MOVE, 8'($urandom));
			else if (r < 68) add_btn(2'($urandom_range(0, 3)), 1'($urandom));
			else if (r < 86) begin
				c = cmds[$urandom_range(0, 15)];
				add(KIND_HOST, c);
				if (c == CMD_RATE || c == CMD_RES) add(KIND_HOST, 8'($urandom));
				else if (c == CMD_WRAP) begin
					add(KIND_HOST, 8'($urandom));
					add(KIND_HOST, CMD_NOWRAP);
				end
				if ($urandom_range(0, 2) == 0) begin
					add(KIND_HOST, CMD_STREAM);
					add(KIND_HOST, CMD_ENABLE);
				end
			end else if (r < 90) add(KIND_HOST, 8'($urandom));
			else if (r < 93) add(3'($urandom_range(5, 7)), 8'($urandom));
			else add_tick({$urandom, $urandom});
		end
		add_takes(300);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) begin
			@(posedge clk);
			no_idle = ((accepted / 100) % 4) == 3;
		end
		repeat (50) @(posedge clk);
		$display("%0d transactions checked, %0d motion packets, %0d bytes dropped on full queue",
			checked, packets, drops);
		if (mismatches == 0 && expected_q.size() == 0 && !timed_out)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/ps2m_pkg.sv
hdl/ps2_mouse_device.sv
test/tb_ps2_mouse_device.sv
